[rtl/core/sss_pkg.sv]
// Shared constants, types and the segment table for the seven-segment scan serializer.
`default_nettype none

package sss_pkg;

  // Default number of multiplexed digits on the display.
  localparam int DIGIT_COUNT_DEFAULT = 4;

  // Width of the value to show and of one serial frame.
  localparam int VALUE_W = 16;
  localparam int FRAME_W = 16;
  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int BITNUM_W = 4;

  // Reciprocal of ten for 16-bit dividends: q = (v * RECIP) >> RECIP_SHIFT.
  localparam int PROD_W      = 32;
  localparam int RECIP_SHIFT = 19;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [VALUE_W-1:0] RECIP = 16'hCCCD;

  // Frame queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Last bit of a frame, where the shift register outputs latch.
  localparam logic [BITNUM_W-1:0] LAST_BIT = 4'd15;

  // Segment patterns for a common-anode display, active low.
  localparam logic [BYTE_W-1:0] SEG_0 = 8'hC0;
  localparam logic [BYTE_W-1:0] SEG_1 = 8'hF9;
  localparam logic [BYTE_W-1:0] SEG_2 = 8'hA4;
  localparam logic [BYTE_W-1:0] SEG_3 = 8'hB0;
  localparam logic [BYTE_W-1:0] SEG_4 = 8'h99;
  localparam logic [BYTE_W-1:0] SEG_5 = 8'h92;
  localparam logic [BYTE_W-1:0] SEG_6 = 8'h82;
  localparam logic [BYTE_W-1:0] SEG_7 = 8'hF8;
  localparam logic [BYTE_W-1:0] SEG_8 = 8'h80;
  localparam logic [BYTE_W-1:0] SEG_9 = 8'h90;

  // Fill level of the frame queue as seen by its neighbors.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [BYTE_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [BYTE_W-1:0] seg;
    case (digit)
      4'd0: seg = SEG_0;
      4'd1: seg = SEG_1;
      4'd2: seg = SEG_2;
      4'd3: seg = SEG_3;
      4'd4: seg = SEG_4;
      4'd5: seg = SEG_5;
      4'd6: seg = SEG_6;
      4'd7: seg = SEG_7;
      4'd8: seg = SEG_8;
      4'd9: seg = SEG_9;
      default: seg = SEG_0;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

[rtl/core/seven_segment_scan_serializer_core.sv]
// Top level of the multiplexed seven-segment scan serializer: front, frame queue and shifter.
// Timing: the delay from an accepted value item to its first bit item grows with DIGIT, the
//   scan position, as the divide-by-ten loop divides once for each lower digit.
// Throughput: the shifter sends one bit a cycle while the receiver does not stall.
// Reset: rst is synchronous and active high; it returns the scan position to digit 0 and
//   empties the frame queue and the output register.
`default_nettype none

module seven_segment_scan_serializer_core #(
  parameter int DIGIT_COUNT = sss_pkg::DIGIT_COUNT_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Value channel: one item is one display refresh.
  input  wire logic                         value_valid,
  output logic                              value_stall,
  input  wire logic [sss_pkg::VALUE_W-1:0]  value,
  // Bit channel: sixteen items per refresh, for the chained shift registers.
  output logic                              bit_valid,
  input  wire logic                         bit_stall,
  output logic                              serial_bit,
  output logic [sss_pkg::BITNUM_W-1:0]      bit_number,
  output logic                              latch_strobe
);

  // The front takes a value, walks it down by repeated division by ten to the digit
  // at the current scan position, looks up the active-low segment byte and pairs it
  // with the one-hot digit select byte. The finished 16-bit frame goes into a short
  // queue, so the front can already work on the next value while the back still
  // shifts out the previous frame.
  logic                         push;
  logic [sss_pkg::FRAME_W-1:0]  wr_frame;
  logic                         pop;
  logic [sss_pkg::FRAME_W-1:0]  rd_frame;
  sss_pkg::q_status_t           q_status;

  sss_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .push        (push),
    .frame       (wr_frame),
    .q_status    (q_status)
  );

  sss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_frame (wr_frame),
    .pop      (pop),
    .rd_frame (rd_frame),
    .status   (q_status)
  );

  // The back sends the segment byte first, then the select byte, MSB first, and
  // marks the sixteenth bit so the shift register outputs latch on it. Its output
  // register lets the next bit wait while the receiver stalls.
  sss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .rd_frame     (rd_frame),
    .pop          (pop),
    .bit_valid    (bit_valid),
    .bit_stall    (bit_stall),
    .serial_bit   (serial_bit),
    .bit_number   (bit_number),
    .latch_strobe (latch_strobe)
  );

endmodule

`default_nettype wire

[rtl/core/sss_front.sv]
// Front part: takes refresh items, extracts the scanned digit and builds the frame.
`default_nettype none

module sss_front #(
  parameter int DIGIT_COUNT = sss_pkg::DIGIT_COUNT_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        value_valid,
  output logic                             value_stall,
  input  wire logic [sss_pkg::VALUE_W-1:0] value,
  output logic                             push,
  output logic [sss_pkg::FRAME_W-1:0]      frame,
  input  wire sss_pkg::q_status_t          q_status
);

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_REM, S_PUSH} state_t;

  state_t                          state;
  logic [IDX_W-1:0]                scan_index;
  logic [IDX_W-1:0]                cnt;
  logic [sss_pkg::VALUE_W-1:0]     work;
  logic [sss_pkg::QUOT_W-1:0]      quot;
  logic [sss_pkg::BYTE_W-1:0]      sel;

  logic                            take;
  logic [sss_pkg::PROD_W-1:0]      product;
  logic [sss_pkg::VALUE_W-1:0]     rem;
  logic [IDX_W-1:0]                scan_index_next;

  // A new item is taken when idle, or while the finished frame leaves this cycle.
  assign value_stall = !((state == S_IDLE) || ((state == S_PUSH) && !q_status.full));
  assign take        = value_valid && !value_stall;
  assign push        = (state == S_PUSH);

  // Divide by ten through the reciprocal; the remainder uses the registered quotient.
  assign product = sss_pkg::PROD_W'(work) * sss_pkg::PROD_W'(sss_pkg::RECIP);
  assign rem     = work - sss_pkg::VALUE_W'({quot, 3'b000})
                        - sss_pkg::VALUE_W'({quot, 1'b0});

  assign scan_index_next = (scan_index == LAST_IDX) ? '0 : scan_index + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_index <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            work       <= value;
            cnt        <= scan_index;
            sel        <= sss_pkg::BYTE_W'(1) << scan_index;
            scan_index <= scan_index_next;
            state      <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt != '0) begin
            work <= sss_pkg::VALUE_W'(product[sss_pkg::PROD_W-1:sss_pkg::RECIP_SHIFT]);
            cnt  <= cnt - IDX_W'(1);
          end else begin
            quot  <= product[sss_pkg::PROD_W-1:sss_pkg::RECIP_SHIFT];
            state <= S_REM;
          end
        end
        S_REM: begin
          frame <= {sss_pkg::seg_of(rem[sss_pkg::DIGIT_W-1:0]), sel};
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (take) begin
            work       <= value;
            cnt        <= scan_index;
            sel        <= sss_pkg::BYTE_W'(1) << scan_index;
            scan_index <= scan_index_next;
            state      <= S_DIV;
          end else if (!q_status.full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_index <= LAST_IDX)
    else $error("scan position out of range");

  a_remainder_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM) |-> (rem < sss_pkg::VALUE_W'(10)))
    else $error("remainder is not a decimal digit");

endmodule

`default_nettype wire

[rtl/core/sss_queue.sv]
// Short frame queue between the front and the back.
`default_nettype none

module sss_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [sss_pkg::FRAME_W-1:0] wr_frame,
  input  wire logic                        pop,
  output logic [sss_pkg::FRAME_W-1:0]      rd_frame,
  output sss_pkg::q_status_t               status
);

  localparam int PTR_W = (sss_pkg::QUEUE_DEPTH > 1) ? $clog2(sss_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sss_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sss_pkg::QUEUE_DEPTH - 1);

  logic [sss_pkg::FRAME_W-1:0] entries [sss_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            count;
  logic                        do_push;
  logic                        do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(sss_pkg::QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_frame     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= wr_frame;
        wr_ptr          <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(sss_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

endmodule

`default_nettype wire

[rtl/core/sss_back.sv]
// Back part: shifts each queued frame out one bit per item, MSB first.
`default_nettype none

module sss_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sss_pkg::q_status_t           q_status,
  input  wire logic [sss_pkg::FRAME_W-1:0]  rd_frame,
  output logic                              pop,
  output logic                              bit_valid,
  input  wire logic                         bit_stall,
  output logic                              serial_bit,
  output logic [sss_pkg::BITNUM_W-1:0]      bit_number,
  output logic                              latch_strobe
);

  logic                          active;
  logic [sss_pkg::FRAME_W-1:0]   sr;
  logic [sss_pkg::BITNUM_W-1:0]  nbit;
  logic                          advance;

  // The output register moves when it is empty or its item is taken.
  assign advance = !bit_valid || !bit_stall;
  assign pop     = advance && !active && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_valid <= 1'b0;
      active    <= 1'b0;
    end else if (advance) begin
      if (active) begin
        serial_bit   <= sr[sss_pkg::FRAME_W-1];
        sr           <= {sr[sss_pkg::FRAME_W-2:0], 1'b0};
        bit_number   <= nbit;
        latch_strobe <= (nbit == sss_pkg::LAST_BIT);
        active       <= (nbit != sss_pkg::LAST_BIT);
        nbit         <= nbit + sss_pkg::BITNUM_W'(1);
        bit_valid    <= 1'b1;
      end else if (!q_status.empty) begin
        serial_bit   <= rd_frame[sss_pkg::FRAME_W-1];
        sr           <= {rd_frame[sss_pkg::FRAME_W-2:0], 1'b0};
        bit_number   <= '0;
        latch_strobe <= 1'b0;
        active       <= 1'b1;
        nbit         <= sss_pkg::BITNUM_W'(1);
        bit_valid    <= 1'b1;
      end else begin
        bit_valid <= 1'b0;
      end
    end
  end

  a_active_has_output: assert property (@(posedge clk) disable iff (rst)
    active |-> bit_valid)
    else $error("frame in progress without a held output bit");

  a_idle_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (bit_valid && !active) |-> latch_strobe)
    else $error("shifter left a frame before its last bit");

  a_bits_contiguous: assert property (@(posedge clk) disable iff (rst)
    (bit_valid && !bit_stall && (bit_number != sss_pkg::LAST_BIT)) |=>
      (bit_valid && (bit_number == sss_pkg::BITNUM_W'($past(bit_number) + 4'd1))))
    else $error("gap or skip inside a frame");

endmodule

`default_nettype wire

[test/tb_seven_segment_scan_serializer_core.sv]
// Self-checking testbench for the seven-segment scan serializer core.
`default_nettype none

module tb_seven_segment_scan_serializer_core;

  // The core runs at its default digit count; the scan position wraps at this value.
  localparam int DIGITS = sss_pkg::DIGIT_COUNT_DEFAULT;

  // A window with no progress on either channel this long means the core has hung.
  // A correct run keeps moving items on one channel or the other well within this limit.
  localparam int HANG_LIMIT = 2000;

  // Extra cycles after the last expected bit, enough to cover the longest latency.
  localparam int DRAIN_CYCLES = 24;

  localparam int RANDOM_ITEMS = 195;

  // Active-low common-anode patterns, indexed by the decimal digit.
  localparam logic [9:0][sss_pkg::BYTE_W-1:0] DIGIT_PATTERNS = {
    sss_pkg::SEG_9, sss_pkg::SEG_8, sss_pkg::SEG_7, sss_pkg::SEG_6, sss_pkg::SEG_5,
    sss_pkg::SEG_4, sss_pkg::SEG_3, sss_pkg::SEG_2, sss_pkg::SEG_1, sss_pkg::SEG_0
  };

  // One bit of a serial frame as the shift register chain should see it.
  typedef struct packed {
    logic                         serial_bit;
    logic [sss_pkg::BITNUM_W-1:0] bit_number;
    logic                         latch_strobe;
  } frame_bit_t;

  // One row of the directed stimulus. Where has_frame is set, the frame was worked out
  // by hand and is used in place of the predicted one.
  typedef struct packed {
    logic [sss_pkg::VALUE_W-1:0] value;
    logic                        has_frame;
    logic [sss_pkg::FRAME_W-1:0] frame;
  } refresh_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         value_valid = 1'b0;
  logic                         value_stall;
  logic [sss_pkg::VALUE_W-1:0]  value = '0;
  logic                         bit_valid;
  logic                         bit_stall = 1'b0;
  logic                         serial_bit;
  logic [sss_pkg::BITNUM_W-1:0] bit_number;
  logic                         latch_strobe;

  // Scan position the core should refresh next, tracked alongside the core.
  int unsigned scan_pos = 0;

  // Bits still to come out of the core, oldest first.
  frame_bit_t pending_bits[$];

  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  // While set, neither side idles: a long stretch of back-to-back traffic.
  logic steady = 1'b0;

  refresh_row_t directed_rows[25];

  seven_segment_scan_serializer_core #(
    .DIGIT_COUNT(DIGITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .bit_valid   (bit_valid),
    .bit_stall   (bit_stall),
    .serial_bit  (serial_bit),
    .bit_number  (bit_number),
    .latch_strobe(latch_strobe)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Frame for one refresh: the segment byte of the digit at the scan position, then the
  // one-hot digit select. Digits come from plain repeated division, so values above 9999
  // show only their lowest four decimal digits and unused high positions show zero.
  function automatic logic [sss_pkg::FRAME_W-1:0] display_frame(
      input logic [sss_pkg::VALUE_W-1:0] v, input int unsigned pos);
    int unsigned rest;
    logic [sss_pkg::BYTE_W-1:0] select;
    rest = v;
    for (int unsigned p = 0; p < pos; p++) rest = rest / 10;
    select = '0;
    select[pos] = 1'b1;
    return {DIGIT_PATTERNS[rest % 10], select};
  endfunction

  // Offers one value item, waits for the core to take it, then queues the sixteen bits it
  // must produce. The sender may idle first; valid is never lowered once raised until the
  // item is taken, and the value is held steady while the core stalls.
  task automatic refresh(input logic [sss_pkg::VALUE_W-1:0] v, input logic has_frame,
                         input logic [sss_pkg::FRAME_W-1:0] typed_frame);
    logic [sss_pkg::FRAME_W-1:0] frame;
    frame_bit_t fb;
    while (!steady && $urandom_range(99) < 6) begin
      value_valid <= 1'b0;
      @(posedge clk);
    end
    value_valid <= 1'b1;
    value       <= v;
    do @(posedge clk); while (value_stall);
    frame = has_frame ? typed_frame : display_frame(v, scan_pos);
    for (int k = 0; k < sss_pkg::FRAME_W; k++) begin
      fb.serial_bit   = frame[sss_pkg::FRAME_W-1-k];
      fb.bit_number   = sss_pkg::BITNUM_W'(k);
      fb.latch_strobe = (sss_pkg::BITNUM_W'(k) == sss_pkg::LAST_BIT);
      pending_bits.push_back(fb);
    end
    scan_pos = (scan_pos + 1) % DIGITS;
  endtask

  // The receiving side stalls now and then, except during the steady stretch.
  always @(posedge clk) begin
    bit_stall <= !steady && ($urandom_range(99) < 6);
  end

  // Every bit the core hands over is checked against the oldest bit still owed.
  always @(posedge clk) begin
    frame_bit_t got;
    frame_bit_t want;
    if (!rst && bit_valid && !bit_stall) begin
      got = '{serial_bit, bit_number, latch_strobe};
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected bit item: serial_bit %b bit_number %0d latch_strobe %b",
                 $time, got.serial_bit, got.bit_number, got.latch_strobe);
        errors++;
      end else begin
        want = pending_bits.pop_front();
        if (got.serial_bit !== want.serial_bit) begin
          $display("%0t: serial_bit mismatch: expected %b, actual %b",
                   $time, want.serial_bit, got.serial_bit);
          errors++;
        end
        if (got.bit_number !== want.bit_number) begin
          $display("%0t: bit_number mismatch: expected %0d, actual %0d",
                   $time, want.bit_number, got.bit_number);
          errors++;
        end
        if (got.latch_strobe !== want.latch_strobe) begin
          $display("%0t: latch_strobe mismatch: expected %b, actual %b",
                   $time, want.latch_strobe, got.latch_strobe);
          errors++;
        end
      end
    end
  end

  // Counts consecutive cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (value_valid && !value_stall) || (bit_valid && !bit_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < HANG_LIMIT) @(posedge clk);
    $display("tb_seven_segment_scan_serializer_core failed");
    $finish;
  end

  initial begin
    int kind;
    logic [sss_pkg::VALUE_W-1:0] v;

    // The scan position starts at digit 0 after reset and steps through all four, so each
    // group of four rows walks the full scan. Frames typed in here are the obvious ones:
    // all zeros, the largest value and all nines.
    directed_rows = '{
      '{16'd0,     1'b1, 16'hC001},
      '{16'd0,     1'b1, 16'hC002},
      '{16'd0,     1'b1, 16'hC004},
      '{16'd0,     1'b1, 16'hC008},
      // 65535: units 5, tens 3, hundreds 5, and the thousands digit of 65 is 5.
      '{16'd65535, 1'b1, 16'h9201},
      '{16'd65535, 1'b1, 16'hB002},
      '{16'd65535, 1'b1, 16'h9204},
      '{16'd65535, 1'b1, 16'h9208},
      '{16'd9999,  1'b1, 16'h9001},
      '{16'd9999,  1'b1, 16'h9002},
      '{16'd9999,  1'b1, 16'h9004},
      '{16'd9999,  1'b1, 16'h9008},
      // Remaining digits 1 through 8, each at one scan position, across the full scan.
      '{16'd1234,  1'b0, 16'h0000},
      '{16'd1234,  1'b0, 16'h0000},
      '{16'd1234,  1'b0, 16'h0000},
      '{16'd1234,  1'b0, 16'h0000},
      '{16'd5678,  1'b0, 16'h0000},
      '{16'd5678,  1'b0, 16'h0000},
      '{16'd5678,  1'b0, 16'h0000},
      '{16'd5678,  1'b0, 16'h0000},
      // Just past the four-digit range, then a wide value whose top digit wraps.
      '{16'd10000, 1'b0, 16'h0000},
      '{16'd12345, 1'b0, 16'h0000},
      // A small value, so the upper positions show zero.
      '{16'd7,     1'b0, 16'h0000},
      // Alternating bit patterns drive every value bit both ways.
      '{16'hAAAA,  1'b0, 16'h0000},
      '{16'h5555,  1'b0, 16'h0000}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      refresh(directed_rows[i].value, directed_rows[i].has_frame, directed_rows[i].frame);
    end

    // Random refreshes: full-range values, values inside the four-digit range, and values
    // above it. The middle part runs without any idling on either side.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 80 && n < 150);
      kind = $urandom_range(2);
      case (kind)
        0: v = sss_pkg::VALUE_W'($urandom);
        1: v = sss_pkg::VALUE_W'($urandom_range(9999));
        default: v = sss_pkg::VALUE_W'($urandom_range(65535, 10000));
      endcase
      refresh(v, 1'b0, '0);
    end
    steady = 1'b0;
    value_valid <= 1'b0;

    // Let every owed bit arrive; the hang watchdog ends the run if they never do.
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_bits.size() != 0) begin
      $display("%0t: %0d bit items never arrived", $time, pending_bits.size());
      errors++;
    end

    if (errors == 0) begin
      $display("tb_seven_segment_scan_serializer_core passed");
    end else begin
      $display("tb_seven_segment_scan_serializer_core failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
